>>> hdl/infix_to_postfix_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter checker
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define IPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, codes and helpers shared by the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // operator codes held on the stack
  localparam logic [2:0] CODE_ADD    = 3'd0;
  localparam logic [2:0] CODE_SUB    = 3'd1;
  localparam logic [2:0] CODE_MUL    = 3'd2;
  localparam logic [2:0] CODE_DIV    = 3'd3;
  localparam logic [2:0] CODE_LPAREN = 3'd4;

  localparam logic [7:0] CHAR_ADD     = 8'h2B;
  localparam logic [7:0] CHAR_SUB     = 8'h2D;
  localparam logic [7:0] CHAR_MUL     = 8'h2A;
  localparam logic [7:0] CHAR_DIV     = 8'h2F;
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef enum logic [2:0] {
    K_CHAR,
    K_OP,
    K_LP,
    K_RP,
    K_END
  } kind_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [2:0] code;
  } stack_cmd_t;

  typedef struct packed {
    logic [2:0] top;
    logic [2:0] below;
  } stack_view_t;

  function automatic logic prec(input logic [2:0] code);
    return (code >= CODE_MUL);
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] c;
    unique case (code)
      CODE_ADD:    c = CHAR_ADD;
      CODE_SUB:    c = CHAR_SUB;
      CODE_MUL:    c = CHAR_MUL;
      CODE_DIV:    c = CHAR_DIV;
      CODE_LPAREN: c = CHAR_LPAREN;
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/ipc_if.sv
// ----------------------------------------------------------------------------
// ipc_if
// Valid/ready channels: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
interface ipc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_expr;

  modport source (output valid, output ch, output end_of_expr, input ready);
  modport sink   (input valid, input ch, input end_of_expr, output ready);
endinterface

interface ipc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       expr_done;
  logic       error;

  modport source (output valid, output out_char, output last, output expr_done,
                  output error, input ready);
  modport sink   (input valid, input out_char, input last, input expr_done,
                  input error, output ready);
endinterface

>>> hdl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// Usage:
//   expr : one request per infix character (ch), or an end marker
//          (end_of_expr) that flushes the stack and yields a newline.
//   post : postfix characters; last marks the final one of a request,
//          expr_done the closing newline, error an unmatched ')' or a
//          push onto a full stack (out_char is then 0).
// Once a request is taken, its work runs as a series of steps: one step
//   per output character, one per push, one to drop a matching '('. No
//   new request is taken until the last step of the current one is done;
//   the single sequencer working the operator stack sets this pace.
// The operator stack is a chain of cells; push and pop shift every cell by
//   one place toward or away from the top, all cells at the same clock edge.
// Reset empties the stack and drops any pending output.
// A stalled receiver holds the output register; the step that would emit
//   next waits, steps without output carry on.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
  input logic       clk,
  input logic       rst,
  ipc_in_if.sink    expr,
  ipc_out_if.source post
);
  import ipc_pkg::*;

  stack_cmd_t  cmd;
  stack_view_t view;
  logic [2:0]  cell_code [STACK_DEPTH];

  ipc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .expr (expr),
    .post (post),
    .view (view),
    .cmd  (cmd)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [2:0] up, down;
    if (i == 0) begin : g_top
      assign up = cmd.code;
    end else begin : g_mid
      assign up = cell_code[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down = cell_code[i];
    end else begin : g_rest
      assign down = cell_code[i+1];
    end
    ipc_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .from_up   (up),
      .from_down (down),
      .code      (cell_code[i])
    );
  end

  assign view.top   = cell_code[0];
  assign view.below = cell_code[1];

endmodule

>>> hdl/ipc_cell.sv
// ----------------------------------------------------------------------------
// ipc_cell
// One stack slot; shifts toward the bottom on push, toward the top on pop.
// ----------------------------------------------------------------------------
module ipc_cell (
  input  logic               clk,
  input  ipc_pkg::stack_cmd_t cmd,
  input  logic [2:0]         from_up,
  input  logic [2:0]         from_down,
  output logic [2:0]         code
);
  import ipc_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      code <= from_up;
    end else if (cmd.pop) begin
      code <= from_down;
    end
  end

endmodule

>>> hdl/ipc_ctrl.sv
// ----------------------------------------------------------------------------
// ipc_ctrl
// Sequencer: decodes a request, steps pops/pushes, drives the output register.
// ----------------------------------------------------------------------------
module ipc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  ipc_in_if.sink               expr,
  ipc_out_if.source            post,
  input  ipc_pkg::stack_view_t view,
  output ipc_pkg::stack_cmd_t  cmd
);
  import ipc_pkg::*;

  state_t           state, state_next;
  kind_t            kind;
  logic [2:0]       code;
  logic [7:0]       ch;
  logic [CNT_W-1:0] count;

  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;
  logic       out_done;
  logic       out_err;

  // one step of work
  logic       want_emit, go, fin;
  logic [7:0] e_char;
  logic       e_last, e_done, e_err;
  logic       do_push, do_pop;

  logic out_free, cnt_nz, one_left, full, top_lp;

  assign out_free = !out_valid || post.ready;
  assign cnt_nz   = (count != '0);
  assign one_left = (count == CNT_W'(1));
  assign full     = (count >= CNT_W'(STACK_DEPTH));
  assign top_lp   = (view.top == CODE_LPAREN);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (expr.valid) state_next = ST_BUSY;
      ST_BUSY: if (go && fin) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    want_emit = 1'b0;
    fin       = 1'b0;
    e_char    = 8'h00;
    e_last    = 1'b0;
    e_done    = 1'b0;
    e_err     = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    if (state == ST_BUSY) begin
      unique case (kind)
        K_CHAR: begin
          want_emit = 1'b1;
          e_char    = ch;
          e_last    = 1'b1;
          fin       = 1'b1;
        end
        K_END: begin
          want_emit = 1'b1;
          if (cnt_nz) begin
            do_pop = 1'b1;
            e_char = code_char(view.top);
          end else begin
            e_char = CHAR_NEWLINE;
            e_last = 1'b1;
            e_done = 1'b1;
            fin    = 1'b1;
          end
        end
        K_OP: begin
          if (cnt_nz && !top_lp && (prec(view.top) >= prec(code))) begin
            // last pop when the loop stops on the entry below
            want_emit = 1'b1;
            do_pop    = 1'b1;
            e_char    = code_char(view.top);
            e_last    = one_left || (view.below == CODE_LPAREN) ||
                        (prec(view.below) < prec(code));
          end else if (full) begin
            want_emit = 1'b1;
            e_err     = 1'b1;
            e_last    = 1'b1;
            fin       = 1'b1;
          end else begin
            do_push = 1'b1;
            fin     = 1'b1;
          end
        end
        K_LP: begin
          fin = 1'b1;
          if (full) begin
            want_emit = 1'b1;
            e_err     = 1'b1;
            e_last    = 1'b1;
          end else begin
            do_push = 1'b1;
          end
        end
        K_RP: begin
          if (cnt_nz && !top_lp) begin
            want_emit = 1'b1;
            do_pop    = 1'b1;
            e_char    = code_char(view.top);
            e_last    = !one_left && (view.below == CODE_LPAREN);
          end else if (cnt_nz) begin
            do_pop = 1'b1;  // drop the matching paren
            fin    = 1'b1;
          end else begin
            want_emit = 1'b1;
            e_err     = 1'b1;
            e_last    = 1'b1;
            fin       = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
    end
  end

  assign go       = !want_emit || out_free;
  assign cmd.push = go && do_push;
  assign cmd.pop  = go && do_pop;
  assign cmd.code = code;

  assign expr.ready     = (state == ST_IDLE);
  assign post.valid     = out_valid;
  assign post.out_char  = out_char;
  assign post.last      = out_last;
  assign post.expr_done = out_done;
  assign post.error     = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
      end
      if (go && want_emit) begin
        out_valid <= 1'b1;
      end else if (post.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && want_emit) begin
      out_char <= e_char;
      out_last <= e_last;
      out_done <= e_done;
      out_err  <= e_err;
    end
    if (expr.valid && expr.ready) begin
      ch <= expr.ch;
      if (expr.end_of_expr) begin
        kind <= K_END;
        code <= CODE_ADD;
      end else begin
        priority case (expr.ch)
          CHAR_ADD:    begin kind <= K_OP; code <= CODE_ADD;    end
          CHAR_SUB:    begin kind <= K_OP; code <= CODE_SUB;    end
          CHAR_MUL:    begin kind <= K_OP; code <= CODE_MUL;    end
          CHAR_DIV:    begin kind <= K_OP; code <= CODE_DIV;    end
          CHAR_LPAREN: begin kind <= K_LP; code <= CODE_LPAREN; end
          CHAR_RPAREN: begin kind <= K_RP; code <= CODE_LPAREN; end
          default:     begin kind <= K_CHAR; code <= CODE_ADD;  end
        endcase
      end
    end
  end

endmodule

>>> hdl/ipc_checker.sv
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module ipc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_done,
  input logic       out_error
);

  `IPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped while stalled")
  `IPC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `IPC_ASSERT_NOW(a_done_newline, out_valid && out_done, out_last && !out_error && out_char == 8'h0A, "bad end newline")
  `IPC_ASSERT_NOW(a_error_form, out_valid && out_error, out_last && out_char == 8'h00 && !out_done, "bad error result")

endmodule

bind infix_to_postfix_converter ipc_checker u_ipc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (expr.valid),
  .in_ready  (expr.ready),
  .out_valid (post.valid),
  .out_ready (post.ready),
  .out_char  (post.out_char),
  .out_last  (post.last),
  .out_done  (post.expr_done),
  .out_error (post.error)
);

>>> test/infix_to_postfix_converter_tb.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Drives infix characters and end markers into the converter. A scoreboard
// runs its own operator stack to work out the postfix stream. Every postfix
// character is checked against that stream, with random stalls on both
// channels in the first two phases and none in the last.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipc_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_REQUESTS = 380;
  localparam int TAIL_CYCLES     = 50;
  localparam int REPORT_LIMIT    = 10;
  localparam int SLOT_W          = $clog2(STACK_DEPTH);

  localparam logic [7:0] OPERATOR_CHARS [4] = '{CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV};

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       expr_done;
    logic       error;
  } postfix_char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } infix_req_t;

  class postfix_scoreboard;
    logic [2:0]    op_codes [STACK_DEPTH];
    int unsigned   op_depth;
    postfix_char_t postfix_due [$];
    int unsigned   failures;

    function new();
      op_depth = 0;
      failures = 0;
    endfunction

    function bit high_prec(logic [2:0] code);
      return code >= CODE_MUL;
    endfunction

    function logic [7:0] code_to_char(logic [2:0] code);
      case (code)
        CODE_ADD:    return CHAR_ADD;
        CODE_SUB:    return CHAR_SUB;
        CODE_MUL:    return CHAR_MUL;
        CODE_DIV:    return CHAR_DIV;
        CODE_LPAREN: return CHAR_LPAREN;
        default:     return 8'h00;
      endcase
    endfunction

    function logic [2:0] operator_code(logic [7:0] c);
      case (c)
        CHAR_ADD: return CODE_ADD;
        CHAR_SUB: return CODE_SUB;
        CHAR_MUL: return CODE_MUL;
        default:  return CODE_DIV;
      endcase
    endfunction

    function logic [2:0] top_code();
      return op_codes[SLOT_W'(op_depth - 1)];
    endfunction

    function void emit(logic [7:0] c, logic done, logic err);
      postfix_char_t r;
      r.out_char  = c;
      r.last      = 1'b0;
      r.expr_done = done;
      r.error     = err;
      postfix_due.push_back(r);
    endfunction

    function void pop_emit();
      op_depth--;
      emit(code_to_char(op_codes[SLOT_W'(op_depth)]), 1'b0, 1'b0);
    endfunction

    // full stack: operator dropped, error result instead
    function void push_code(logic [2:0] code);
      if (op_depth >= STACK_DEPTH) begin
        emit(8'h00, 1'b0, 1'b1);
      end else begin
        op_codes[SLOT_W'(op_depth)] = code;
        op_depth++;
      end
    endfunction

    function void note_request(infix_req_t req);
      int unsigned queued;
      logic [2:0]  code;
      queued = postfix_due.size();
      if (req.end_mark) begin
        while (op_depth > 0) pop_emit();
        emit(CHAR_NEWLINE, 1'b1, 1'b0);
      end else begin
        case (req.ch)
          CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV: begin
            code = operator_code(req.ch);
            while (op_depth > 0 && top_code() != CODE_LPAREN &&
                   high_prec(top_code()) >= high_prec(code))
              pop_emit();
            push_code(code);
          end
          CHAR_LPAREN: push_code(CODE_LPAREN);
          CHAR_RPAREN: begin
            while (op_depth > 0 && top_code() != CODE_LPAREN) pop_emit();
            // drop the matching '(' or flag an unmatched ')'
            if (op_depth > 0) op_depth--;
            else emit(8'h00, 1'b0, 1'b1);
          end
          default: emit(req.ch, 1'b0, 1'b0);
        endcase
      end
      if (postfix_due.size() > queued) postfix_due[postfix_due.size() - 1].last = 1'b1;
    endfunction

    function void check_result(postfix_char_t got);
      postfix_char_t want;
      if (postfix_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: char %h last %b done %b error %b",
                   got.out_char, got.last, got.expr_done, got.error);
        return;
      end
      want = postfix_due.pop_front();
      if (got.out_char !== want.out_char || got.last !== want.last ||
          got.expr_done !== want.expr_done || got.error !== want.error) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch: expected char %h last %b done %b error %b, got char %h last %b done %b error %b",
                   want.out_char, want.last, want.expr_done, want.error,
                   got.out_char, got.last, got.expr_done, got.error);
      end
    endfunction

    function int unsigned pending();
      return postfix_due.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;

  ipc_in_if  expr_ch ();
  ipc_out_if post_ch ();

  infix_to_postfix_converter DUT (
    .clk  (clk),
    .rst  (rst),
    .expr (expr_ch),
    .post (post_ch)
  );

  postfix_scoreboard sb;
  infix_req_t        stimulus [$];
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    post_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      post_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    infix_req_t    taken;
    postfix_char_t got;
    if (!rst) begin
      if (expr_ch.valid && expr_ch.ready) begin
        taken.ch       = expr_ch.ch;
        taken.end_mark = expr_ch.end_of_expr;
        sb.note_request(taken);
      end
      if (post_ch.valid && post_ch.ready) begin
        got.out_char  = post_ch.out_char;
        got.last      = post_ch.last;
        got.expr_done = post_ch.expr_done;
        got.error     = post_ch.error;
        sb.check_result(got);
      end
    end
  end

  // ends the run after too long without any request or result moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst === 1'b0);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((expr_ch.valid && expr_ch.ready) || (post_ch.valid && post_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic void add_request(logic [7:0] c, logic end_mark);
    infix_req_t req;
    req.ch       = c;
    req.end_mark = end_mark;
    stimulus.push_back(req);
  endfunction

  function automatic logic [7:0] random_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c inside {CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV, CHAR_LPAREN, CHAR_RPAREN});
    return c;
  endfunction

  function automatic logic [7:0] random_operator();
    return OPERATOR_CHARS[2'($urandom_range(3))];
  endfunction

  // well-formed expression, nesting up to four levels, closed by an end marker
  function automatic void build_expression();
    int operands;
    int open;
    operands = $urandom_range(8, 1);
    open = 0;
    while (operands > 0) begin
      if (open < 4 && $urandom_range(3) == 0) begin
        add_request(CHAR_LPAREN, 1'b0);
        open++;
      end else begin
        add_request(random_operand(), 1'b0);
        operands--;
        while (open > 0 && $urandom_range(2) == 0) begin
          add_request(CHAR_RPAREN, 1'b0);
          open--;
        end
        if (operands > 0) add_request(random_operator(), 1'b0);
      end
    end
    repeat (open) add_request(CHAR_RPAREN, 1'b0);
    add_request(8'($urandom_range(255)), 1'b1);
  endfunction

  // nesting around the stack depth: overflow, unmatched ')' and long flushes
  function automatic void build_deep_nesting();
    int levels;
    int closes;
    levels = $urandom_range(36, 28);
    closes = $urandom_range(levels + 2, 0);
    repeat (levels) add_request(CHAR_LPAREN, 1'b0);
    add_request(random_operand(), 1'b0);
    repeat ($urandom_range(3)) begin
      add_request(random_operator(), 1'b0);
      add_request(random_operand(), 1'b0);
    end
    repeat (closes) add_request(CHAR_RPAREN, 1'b0);
    add_request(8'($urandom_range(255)), 1'b1);
  endfunction

  function automatic void build_broken();
    repeat ($urandom_range(10, 1)) begin
      case ($urandom_range(3))
        0: add_request(random_operand(), 1'b0);
        1: add_request(random_operator(), 1'b0);
        2: add_request(CHAR_LPAREN, 1'b0);
        default: add_request(CHAR_RPAREN, 1'b0);
      endcase
    end
    if ($urandom_range(1) == 0) add_request(8'($urandom_range(255)), 1'b1);
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(6, 1))
      add_request(8'($urandom_range(255)), $urandom_range(7) == 0);
  endfunction

  task automatic send_request(infix_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      expr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    expr_ch.valid       <= 1'b1;
    expr_ch.ch          <= req.ch;
    expr_ch.end_of_expr <= req.end_mark;
    do @(posedge clk); while (!expr_ch.ready);
  endtask

  task automatic drain_expected();
    expr_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int random_start;
    int phase_len;
    int picks;
    int r;
    sb = new();
    expr_ch.valid       <= 1'b0;
    expr_ch.ch          <= 8'h00;
    expr_ch.end_of_expr <= 1'b0;

    // directed: byte extremes, every operator, parens, errors, silent pushes
    add_request(8'h00, 1'b0);
    add_request(CHAR_ADD, 1'b0);
    add_request(8'hFF, 1'b0);
    add_request(CHAR_MUL, 1'b0);
    add_request(CHAR_LPAREN, 1'b0);
    add_request("b", 1'b0);
    add_request(CHAR_SUB, 1'b0);
    add_request("c", 1'b0);
    add_request(CHAR_RPAREN, 1'b0);
    add_request(CHAR_DIV, 1'b0);
    add_request("d", 1'b0);
    add_request(CHAR_SUB, 1'b0);
    add_request("e", 1'b0);
    add_request(8'hFF, 1'b1);
    add_request(CHAR_RPAREN, 1'b0);
    add_request("f", 1'b0);
    add_request(CHAR_ADD, 1'b0);
    add_request("g", 1'b0);
    add_request(CHAR_RPAREN, 1'b0);
    add_request(8'h00, 1'b1);
    add_request(CHAR_NEWLINE, 1'b0);
    add_request(CHAR_RPAREN, 1'b1);

    random_start = stimulus.size();
    picks = 0;
    while (stimulus.size() - random_start < RANDOM_REQUESTS) begin
      r = $urandom_range(99);
      if (picks % 10 == 3) build_deep_nesting();
      else if (r < 75) build_expression();
      else if (r < 90) build_broken();
      else build_noise();
      picks++;
    end

    send_idle_pct = 15;
    recv_idle_pct = 68;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    phase_len = stimulus.size() / 3;
    for (int i = 0; i < stimulus.size(); i++) begin
      if (i == phase_len) begin
        drain_expected();
        send_idle_pct = 68;
        recv_idle_pct = 15;
      end else if (i == 2 * phase_len) begin
        drain_expected();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_request(stimulus[i]);
    end
    drain_expected();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ipc_pkg.sv
hdl/ipc_if.sv
hdl/ipc_cell.sv
hdl/ipc_ctrl.sv
hdl/infix_to_postfix_converter.sv
hdl/ipc_checker.sv
test/infix_to_postfix_converter_tb.sv
